### rtl/adsr_pkg.sv
// Shared types, constants and helpers for the ADSR envelope generator.
// Depends on nothing; every other file in rtl/ imports it.
package adsr_pkg;

    localparam int LEVEL_W    = 17;
    localparam int FACTOR_W   = 16;
    localparam int SAMPLES_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PHASE_W    = 2;
    localparam int PROD_W     = LEVEL_W + FACTOR_W;

    localparam int COUNT_BITS_DEFAULT = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_SAMPLES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES   = 3'd5;

    // Reset values of the registers
    localparam logic [LEVEL_W-1:0]   RST_ATTACK_STEP     = 17'd65536;
    localparam logic [FACTOR_W-1:0]  RST_DECAY_FACTOR    = 16'd0;
    localparam logic [LEVEL_W-1:0]   RST_TARGET_LEVEL    = 17'd65536;
    localparam logic [LEVEL_W-1:0]   RST_RELEASE_STEP    = 17'd65536;
    localparam logic [SAMPLES_W-1:0] RST_SUSTAIN_SAMPLES = 24'd44100;
    localparam logic [SAMPLES_W-1:0] RST_TOTAL_SAMPLES   = 24'd44100;

    // 0.5 LSB of the Q16 product, used for round half up
    localparam logic [PROD_W-1:0] HALF_ROUND = 33'd32768;

    // Output phase codes
    localparam logic [PHASE_W-1:0] PHASE_CODE_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DECAY   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'b001,
        PH_DECAY   = 3'b010,
        PH_RELEASE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   attack_step;
        logic [FACTOR_W-1:0]  decay_factor;
        logic [LEVEL_W-1:0]   target_level;
        logic [LEVEL_W-1:0]   release_step;
        logic [SAMPLES_W-1:0] sustain_samples;
        logic [SAMPLES_W-1:0] total_samples;
    } adsr_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               done_res;
    } adsr_result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_ATTACK:  code = PHASE_CODE_ATTACK;
            PH_DECAY:   code = PHASE_CODE_DECAY;
            PH_RELEASE: code = PHASE_CODE_RELEASE;
            default:    code = PHASE_CODE_RELEASE;
        endcase
        return code;
    endfunction

endpackage

### rtl/adsr_envelope_generator_core.sv
// Top level of the ADSR envelope generator: handshakes, state and result registers.
// Depends on adsr_pkg, adsr_cfg_regs and adsr_step.
//
//  channel   | signals                                   | dir | role
//  ----------+-------------------------------------------+-----+---------------------------
//  tick      | tick_valid, tick_ready, restart           | in  | one transaction per sample
//  sample    | sample_valid, sample_ready, level, phase, | out | one result per tick
//            | done_res                                  |     |
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | register writes
//
// Each tick passes from acceptance through the input register, then through the step
// logic into the result register. One tick is accepted every cycle while the sample side
// does not stall; the single multiply of the decay path sets the clock period.
// A stalled sample side holds the result register; the input register still takes one
// more tick, after which tick_ready drops until the result is taken.
// Reset clears the envelope state to attack at level zero and loads the register
// defaults. cfg_ready is always high; write only while no tick is in flight.
module adsr_envelope_generator_core #(
    parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  logic                             restart,
    output logic                             sample_valid,
    input  logic                             sample_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]     level,
    output logic [adsr_pkg::PHASE_W-1:0]     phase,
    output logic                             done_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adsr_pkg::*;

    adsr_cfg_t cfg;

    // Input register
    logic in_valid_reg;
    logic in_valid_next;
    logic in_restart_reg;

    // Envelope state
    phase_t                ph_reg;
    phase_t                ph_next;
    logic [LEVEL_W-1:0]    env_level_reg;
    logic [LEVEL_W-1:0]    env_level_next;
    logic [COUNT_BITS-1:0] position_reg;
    logic [COUNT_BITS-1:0] position_next;
    logic [COUNT_BITS-1:0] hold_reg;
    logic [COUNT_BITS-1:0] hold_next;

    // Result register
    logic         out_valid_reg;
    logic         out_valid_next;
    adsr_result_t out_reg;
    adsr_result_t out_next;

    logic tick_fire;
    logic out_load;
    logic step_fire;

    assign cfg_ready = 1'b1;

    adsr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    adsr_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cfg          (cfg),
        .restart      (in_restart_reg),
        .phase_cur    (ph_reg),
        .level_cur    (env_level_reg),
        .position_cur (position_reg),
        .hold_cur     (hold_reg),
        .phase_new    (ph_next),
        .level_new    (env_level_next),
        .position_new (position_next),
        .hold_new     (hold_next),
        .result       (out_next)
    );

    // The result register loads when empty or being drained this cycle;
    // the input register refills whenever its tick moves on.
    assign out_load   = !out_valid_reg || sample_ready;
    assign step_fire  = in_valid_reg && out_load;
    assign tick_ready = !in_valid_reg || out_load;
    assign tick_fire  = tick_valid && tick_ready;

    assign in_valid_next  = tick_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_fire ? 1'b1 : (sample_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ph_reg        <= PH_ATTACK;
            env_level_reg <= '0;
            position_reg  <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Advance the envelope only when the tick moves into the result register
            if (step_fire)
            begin
                ph_reg        <= ph_next;
                env_level_reg <= env_level_next;
                position_reg  <= position_next;
                hold_reg      <= hold_next;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            in_restart_reg <= restart;
        end
        if (step_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign sample_valid = out_valid_reg;
    assign level        = out_reg.level;
    assign phase        = out_reg.phase;
    assign done_res     = out_reg.done_res;

    // A finished envelope reports a zero level
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && done_res) |-> (level == '0))
    else $error("done sample with nonzero level");

    // A tick leaving the input register always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> sample_valid)
    else $error("tick advanced without a result");

    // Position moves by at most one per tick, or a restart drops it to zero or one
    assert property (@(posedge clk) disable iff (!rst_n)
        (position_reg == $past(position_reg)) ||
        (position_reg == $past(position_reg) + 1'b1) ||
        (position_reg <= COUNT_BITS'(1)))
    else $error("position jumped");

    // The hold counter only runs once attack is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg != '0) |-> (ph_reg != PH_ATTACK))
    else $error("hold counter running in attack");

endmodule

### rtl/adsr_cfg_regs.sv
// Configuration register file for the ADSR envelope generator.
// Depends on adsr_pkg for register indexes, reset values and adsr_cfg_t.
module adsr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] wr_data,
    output adsr_pkg::adsr_cfg_t            cfg
);
    import adsr_pkg::*;

    adsr_cfg_t cfg_reg;
    adsr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ATTACK_STEP:     cfg_next.attack_step     = wr_data[LEVEL_W-1:0];
                REG_DECAY_FACTOR:    cfg_next.decay_factor    = wr_data[FACTOR_W-1:0];
                REG_TARGET_LEVEL:    cfg_next.target_level    = wr_data[LEVEL_W-1:0];
                REG_RELEASE_STEP:    cfg_next.release_step    = wr_data[LEVEL_W-1:0];
                REG_SUSTAIN_SAMPLES: cfg_next.sustain_samples = wr_data[SAMPLES_W-1:0];
                REG_TOTAL_SAMPLES:   cfg_next.total_samples   = wr_data[SAMPLES_W-1:0];
                default:             cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step     <= RST_ATTACK_STEP;
            cfg_reg.decay_factor    <= RST_DECAY_FACTOR;
            cfg_reg.target_level    <= RST_TARGET_LEVEL;
            cfg_reg.release_step    <= RST_RELEASE_STEP;
            cfg_reg.sustain_samples <= RST_SUSTAIN_SAMPLES;
            cfg_reg.total_samples   <= RST_TOTAL_SAMPLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/adsr_step.sv
// Per-sample update of the envelope: next state and the result of one tick.
// Depends on adsr_pkg for adsr_cfg_t, adsr_result_t, phase_t and constants.
module adsr_step #(
    parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
    input  adsr_pkg::adsr_cfg_t              cfg,
    input  logic                             restart,
    input  adsr_pkg::phase_t                 phase_cur,
    input  logic [adsr_pkg::LEVEL_W-1:0]     level_cur,
    input  logic [COUNT_BITS-1:0]            position_cur,
    input  logic [COUNT_BITS-1:0]            hold_cur,
    output adsr_pkg::phase_t                 phase_new,
    output logic [adsr_pkg::LEVEL_W-1:0]     level_new,
    output logic [COUNT_BITS-1:0]            position_new,
    output logic [COUNT_BITS-1:0]            hold_new,
    output adsr_pkg::adsr_result_t           result
);
    import adsr_pkg::*;

    localparam int CMP_W = (COUNT_BITS > SAMPLES_W) ? COUNT_BITS : SAMPLES_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t               ph;
    logic [LEVEL_W-1:0]   lvl;
    logic [COUNT_BITS-1:0] pos;
    logic [COUNT_BITS-1:0] hold;
    logic                 done;

    logic [LEVEL_W:0]     attack_sum;
    logic [LEVEL_W-1:0]   attack_lvl;

    logic                 below;
    logic [LEVEL_W-1:0]   delta;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    prod_rnd;
    logic [LEVEL_W-1:0]   pull;
    logic [LEVEL_W:0]     above_sum;
    logic [LEVEL_W-1:0]   decay_lvl;
    logic [COUNT_BITS-1:0] hold_inc;
    logic                 hold_end;

    logic [LEVEL_W-1:0]   release_lvl;
    logic [COUNT_BITS-1:0] pos_inc;

    // Rewind first when restart is set
    assign ph   = restart ? PH_ATTACK : phase_cur;
    assign lvl  = restart ? '0 : level_cur;
    assign pos  = restart ? '0 : position_cur;
    assign hold = restart ? '0 : hold_cur;

    assign done = CMP_W'(pos) >= CMP_W'(cfg.total_samples);

    // Attack: saturating add
    assign attack_sum = {1'b0, lvl} + {1'b0, cfg.attack_step};
    assign attack_lvl = attack_sum[LEVEL_W] ? '1 : attack_sum[LEVEL_W-1:0];

    // Decay: pull toward sustain by the rounded retained distance
    assign below     = lvl <= cfg.target_level;
    assign delta     = below ? (cfg.target_level - lvl) : (lvl - cfg.target_level);
    assign prod      = PROD_W'(delta) * PROD_W'(cfg.decay_factor);
    assign prod_rnd  = prod + HALF_ROUND;
    assign pull      = prod_rnd[PROD_W-1:FACTOR_W];
    assign above_sum = {1'b0, cfg.target_level} + {1'b0, pull};
    assign decay_lvl = below ? (cfg.target_level - pull) : above_sum[LEVEL_W-1:0];
    assign hold_inc  = (hold == COUNT_MAX) ? hold : hold + 1'b1;
    assign hold_end  = CMP_W'(hold_inc) >= CMP_W'(cfg.sustain_samples);

    // Release: subtract and floor at zero
    assign release_lvl = (lvl > cfg.release_step) ? (lvl - cfg.release_step) : '0;

    assign pos_inc = (pos == COUNT_MAX) ? pos : pos + 1'b1;

    always_comb
    begin
        phase_new    = ph;
        level_new    = lvl;
        position_new = pos;
        hold_new     = hold;
        if (!done)
        begin
            position_new = pos_inc;
            unique case (ph)
                PH_ATTACK:
                begin
                    level_new = attack_lvl;
                    phase_new = attack_lvl[LEVEL_W-1] ? PH_DECAY : PH_ATTACK;
                end
                PH_DECAY:
                begin
                    level_new = decay_lvl;
                    hold_new  = hold_inc;
                    phase_new = hold_end ? PH_RELEASE : PH_DECAY;
                end
                PH_RELEASE:
                begin
                    level_new = release_lvl;
                    phase_new = PH_RELEASE;
                end
                default:
                begin
                    level_new = release_lvl;
                    phase_new = PH_RELEASE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.phase    = phase_code(phase_new);
        result.done_res = done;
        result.level    = done ? '0 : level_new;
    end

endmodule
